>>> src/olr_pkg.sv
// Shared constants, payload types and controller/datapath interface types.
package olr_pkg;

   localparam int BUF_DEPTH = 256;
   localparam int STR_SIZE  = 32;
   localparam int PTR_W     = $clog2(BUF_DEPTH);
   localparam int IDX_W     = $clog2(STR_SIZE);

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_DRAIN = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [7:0] packet_id;
      logic       is_last;
      logic       more_pending;
   } rsp_item_type;

   typedef struct packed {
      logic write;
      logic clear;
      logic start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
   } status_type;

endpackage

>>> src/olr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/olr_ctrl.sv
// Controller state machine: request decode, drain sequencing, result valid.
module olr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output olr_pkg::cmd_type    cmd,
   input  olr_pkg::status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic req_xfer;
   logic load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign load      = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_code)
                  olr_pkg::REQ_WRITE: cmd.write = 1'b1;
                  olr_pkg::REQ_CLEAR: cmd.clear = 1'b1;
                  olr_pkg::REQ_DRAIN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            if (load) begin
               cmd.emit     = 1'b1;
               out_valid_in = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> src/olr_datapath.sv
// Datapath: ring pointers, packet counter, string index and result register.
module olr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  olr_pkg::cmd_type           cmd,
   output olr_pkg::status_type        status,
   input  logic [7:0]                 data_byte,
   output logic                       ram_wr_en,
   output logic [olr_pkg::PTR_W-1:0]  ram_wr_addr,
   output logic [7:0]                 ram_wr_data,
   output logic [olr_pkg::PTR_W-1:0]  ram_rd_addr,
   input  logic [7:0]                 ram_rd_data,
   output olr_pkg::rsp_item_type      rsp_data
);

   localparam int PW = olr_pkg::PTR_W;
   localparam int IW = olr_pkg::IDX_W;
   localparam logic [PW-1:0] PTR_LAST = PW'(olr_pkg::BUF_DEPTH - 1);
   localparam logic [IW-1:0] IDX_LAST = IW'(olr_pkg::STR_SIZE - 1);
   localparam logic [31:0]   TAKE_MAX = 32'(olr_pkg::STR_SIZE - 1);

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]    pkt_ff, pkt_in;
   logic [IW-1:0] take_ff, take_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          more_ff, more_in;
   olr_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [PW-1:0] len;
   logic          full;
   logic          from_ring;
   logic [PW-1:0] wr_next, rd_next;

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign len  = (wr_ptr_ff >= rd_ptr_ff) ? wr_ptr_ff - rd_ptr_ff
                                          : PW'(32'(wr_ptr_ff) + 32'(olr_pkg::BUF_DEPTH)
                                                - 32'(rd_ptr_ff));
   assign full      = (len == PTR_LAST);
   assign from_ring = (idx_ff < take_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      pkt_in    = pkt_ff;
      take_in   = take_ff;
      idx_in    = idx_ff;
      more_in   = more_ff;
      rsp_in    = rsp_ff;
      if (cmd.write) begin
         wr_ptr_in = wr_next;
         if (full) begin
            rd_ptr_in = rd_next;
         end
      end
      if (cmd.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end
      if (cmd.start) begin
         pkt_in  = pkt_ff + 8'd1;
         idx_in  = '0;
         more_in = (32'(len) > TAKE_MAX);
         take_in = (32'(len) > TAKE_MAX) ? IDX_LAST : IW'(len);
      end
      if (cmd.emit) begin
         rsp_in.out_byte     = from_ring ? ram_rd_data : 8'd0;
         rsp_in.byte_valid   = from_ring;
         rsp_in.packet_id    = pkt_ff;
         rsp_in.is_last      = (idx_ff == IDX_LAST);
         rsp_in.more_pending = more_ff;
         idx_in              = idx_ff + 1'b1;
         if (from_ring) begin
            rd_ptr_in = rd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         pkt_ff    <= 8'd1;
         take_ff   <= '0;
         idx_ff    <= '0;
         more_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         pkt_ff    <= pkt_in;
         take_ff   <= take_in;
         idx_ff    <= idx_in;
         more_ff   <= more_in;
      end
      rsp_ff <= rsp_in;
   end

   assign status.idx_last = (idx_ff == IDX_LAST);
   assign ram_wr_en       = cmd.write;
   assign ram_wr_addr     = wr_ptr_ff;
   assign ram_wr_data     = data_byte;
   assign ram_rd_addr     = rd_ptr_in;
   assign rsp_data        = rsp_ff;

endmodule

>>> src/overwriting_log_ring_with_drain.sv
// Top level: overwriting byte log ring with notify-string drain.
//
// Requests arrive on the req_ channel (valid/ready): a write appends
// data_byte, dropping the oldest byte once the ring holds BUF_DEPTH-1
// bytes; a drain emits one string of STR_SIZE results on the rsp_ channel;
// a clear empties the ring. Code 3 is accepted and ignored.
// Write, clear and ignored requests leave req_ready high, so a new request
// can follow in the next cycle. An accepted drain moves the controller to
// its emit state, which emits one result per cycle while rsp_ready
// stays high, each into the output register; the next request is
// taken once the final result sits in the output register.
// The ring read port is prefetched one entry ahead, which sets the one
// result per cycle rate. When the receiver stalls, the current result
// holds in the output register and the drain waits.
// Reset empties the ring and sets the packet count to one; no clearing
// pass runs, as only bytes written after the last reset or clear are read.
module overwriting_log_ring_with_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olr_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output olr_pkg::rsp_item_type rsp_data
);

   olr_pkg::cmd_type    cmd;
   olr_pkg::status_type status;

   logic                      ram_wr_en;
   logic [olr_pkg::PTR_W-1:0] ram_wr_addr;
   logic [7:0]                ram_wr_data;
   logic [olr_pkg::PTR_W-1:0] ram_rd_addr;
   logic [7:0]                ram_rd_data;

   olr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   olr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_data.data_byte),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_data    (rsp_data)
   );

   olr_ram #(
      .WIDTH (8),
      .DEPTH (olr_pkg::BUF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> sim/overwriting_log_ring_with_drain_tb.sv
// Testbench for the overwriting byte log ring: directed and random traffic against a ring predictor.
`timescale 1ns / 1ps

module overwriting_log_ring_with_drain_tb;
   import olr_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 120;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;

   logic [7:0]       ring_mem [BUF_DEPTH];
   logic [PTR_W-1:0] wr_idx;
   logic [PTR_W-1:0] rd_idx;
   logic [7:0]       packet_seq;
   rsp_item_type     expected_string_bytes [$];
   rsp_item_type     want_byte;

   int   mismatch_count;
   int   idle_cycles;
   int   ready_hold;
   logic quiet;

   overwriting_log_ring_with_drain dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic ring_apply_request(input req_item_type item);
      logic [PTR_W-1:0] fill;
      int               take;
      logic             more;
      rsp_item_type     drained [STR_SIZE];
      fill = wr_idx - rd_idx;
      case (item.req_type)
         REQ_WRITE: begin
            if (fill >= BUF_DEPTH - 1)
               rd_idx = rd_idx + 1'b1;
            ring_mem[wr_idx] = item.data_byte;
            wr_idx = wr_idx + 1'b1;
         end
         REQ_CLEAR: begin
            wr_idx = '0;
            rd_idx = '0;
            foreach (ring_mem[i])
               ring_mem[i] = 8'h00;
         end
         REQ_DRAIN: begin
            take = (fill > STR_SIZE - 1) ? STR_SIZE - 1 : int'(fill);
            packet_seq = packet_seq + 8'd1;
            for (int i = 0; i < STR_SIZE; i++) begin
               if (i < take) begin
                  drained[i].out_byte = ring_mem[rd_idx];
                  drained[i].byte_valid = 1'b1;
                  rd_idx = rd_idx + 1'b1;
               end else begin
                  drained[i].out_byte = 8'h00;
                  drained[i].byte_valid = 1'b0;
               end
               drained[i].packet_id = packet_seq;
               drained[i].is_last = (i == STR_SIZE - 1);
            end
            more = (wr_idx != rd_idx);
            for (int i = 0; i < STR_SIZE; i++) begin
               drained[i].more_pending = more;
               expected_string_bytes.push_back(drained[i]);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
      req_item_type item;
      item.req_type = kind;
      item.data_byte = value;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      ring_apply_request(item);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_string_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_string_bytes.size() == 0) begin
            report_mismatch("unexpected transfer", int'(rsp_data), 0);
         end else begin
            want_byte = expected_string_bytes.pop_front();
            if (rsp_data.out_byte !== want_byte.out_byte)
               report_mismatch("out_byte", rsp_data.out_byte, want_byte.out_byte);
            if (rsp_data.byte_valid !== want_byte.byte_valid)
               report_mismatch("byte_valid", rsp_data.byte_valid, want_byte.byte_valid);
            if (rsp_data.packet_id !== want_byte.packet_id)
               report_mismatch("packet_id", rsp_data.packet_id, want_byte.packet_id);
            if (rsp_data.is_last !== want_byte.is_last)
               report_mismatch("is_last", rsp_data.is_last, want_byte.is_last);
            if (rsp_data.more_pending !== want_byte.more_pending)
               report_mismatch("more_pending", rsp_data.more_pending, want_byte.more_pending);
         end
      end
   end

   always @(negedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 20);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold <= $urandom_range(0, 11);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** overwriting_log_ring_with_drain: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_drain();
      send_req(REQ_DRAIN, 8'h00);
   endtask

   task automatic test_byte_extremes();
      send_req(REQ_WRITE, 8'h00);
      send_req(REQ_WRITE, 8'hFF);
      send_req(REQ_WRITE, 8'h55);
      send_req(REQ_WRITE, 8'hAA);
      send_req(REQ_WRITE, 8'h01);
      send_req(REQ_WRITE, 8'h80);
      send_req(REQ_DRAIN, 8'hFF);
   endtask

   task automatic test_ignored_code();
      send_req(REQ_WRITE, 8'h3C);
      send_req(REQ_UNUSED, 8'hFF);
      send_req(REQ_UNUSED, 8'h00);
      send_req(REQ_DRAIN, 8'h00);
   endtask

   task automatic test_clear();
      send_req(REQ_WRITE, 8'h11);
      send_req(REQ_WRITE, 8'h22);
      send_req(REQ_WRITE, 8'h33);
      send_req(REQ_CLEAR, 8'hFF);
      send_req(REQ_DRAIN, 8'h00);
      send_req(REQ_CLEAR, 8'h00);
      send_req(REQ_DRAIN, 8'h00);
   endtask

   task automatic test_ring_overflow();
      for (int i = 0; i < BUF_DEPTH + 14; i++)
         send_req(REQ_WRITE, 8'($urandom_range(0, 255)));
      for (int i = 0; i < 10; i++)
         send_req(REQ_DRAIN, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_traffic();
      int   sent;
      int   pick;
      int   burst;
      logic paused;
      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - 30)
            quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
               send_req(REQ_WRITE, 8'($urandom_range(0, 255)));
            send_req(REQ_DRAIN, 8'($urandom_range(0, 255)));
            sent += burst + 1;
         end else if (pick < 80) begin
            send_req(REQ_DRAIN, 8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 88) begin
            send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
            sent++;
         end else if (pick < 94) begin
            send_req(REQ_WRITE, 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_req(REQ_UNUSED, 8'($urandom_range(0, 255)));
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_all_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      ready_hold = 0;
      quiet = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      wr_idx = '0;
      rd_idx = '0;
      packet_seq = 8'd1;
      foreach (ring_mem[i])
         ring_mem[i] = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_empty_drain();
      test_byte_extremes();
      test_ignored_code();
      test_clear();
      test_ring_overflow();
      test_random_traffic();

      wait_all_results();
      repeat (4 * STR_SIZE) @(posedge clock);
      if (mismatch_count == 0 && expected_string_bytes.size() == 0)
         $display("** overwriting_log_ring_with_drain: PASSED **");
      else
         $display("** overwriting_log_ring_with_drain: FAILED **");
      $finish;
   end

endmodule
